// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the kinematics block.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define AKG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define AKG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKG_ASSERT(lbl, prop, msg)
`define AKG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/akg_pkg.sv =====
// Package for the arm kinematics / gravity torque block: constants, types, helpers.
// Depends on nothing.
`default_nettype none
package akg_pkg;
  localparam int AKG_CORDIC_STEPS = 16;
  localparam int AKG_TAB_LEN      = 24;

  localparam int AKG_ZW  = 32;  // CORDIC angle, 0.01 deg / 65536
  localparam int AKG_XW  = 34;  // CORDIC x / y, Q30
  localparam int AKG_SCW = 18;  // sine / cosine, Q16

  localparam logic signed [AKG_XW-1:0] AKG_GAIN_Q30 = 34'sd652032875;
  localparam logic signed [16:0] AKG_LEN1 = 17'sd25300;
  localparam logic signed [16:0] AKG_LEN2 = 17'sd30000;
  localparam logic signed [23:0] AKG_TQ_A = 24'sd4480604;
  localparam logic signed [23:0] AKG_TQ_B = 24'sd3286132;
  localparam logic signed [23:0] AKG_TQ_C = 24'sd3418168;

  localparam logic signed [AKG_ZW-1:0] AKG_ATAN [AKG_TAB_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865, 32'sd11730358, 32'sd5866610, 32'sd2933484,
    32'sd1466765, 32'sd733385, 32'sd366693, 32'sd183346,
    32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
    32'sd5730, 32'sd2865, 32'sd1432, 32'sd716,
    32'sd358, 32'sd179, 32'sd90, 32'sd45
  };

  // reduced CORDIC start angle
  typedef struct packed {
    logic                    flip;
    logic signed [AKG_ZW-1:0] z;
  } akg_ang_t;

  // wrap to one turn, fold into +-90 deg, note whether cosine flips
  function automatic akg_ang_t akg_wrap(input logic signed [16:0] a);
    logic signed [18:0] r;
    logic signed [18:0] ae;
    akg_ang_t res;
    ae = 19'(a);
    if (ae < 0) begin
      r = (ae + 19'sd36000 < 0) ? ae + 19'sd72000 : ae + 19'sd36000;
    end else begin
      r = (ae >= 19'sd36000) ? ae - 19'sd36000 : ae;
    end
    if (r > 19'sd18000) r = r - 19'sd36000;
    res.flip = 1'b0;
    if (r > 19'sd9000) begin
      r = 19'sd18000 - r;
      res.flip = 1'b1;
    end else if (r < -19'sd9000) begin
      r = -19'sd18000 - r;
      res.flip = 1'b1;
    end
    res.z = AKG_ZW'(r) <<< 16;
    return res;
  endfunction

  // clamp to a signed range of w bits
  function automatic logic signed [63:0] akg_sat(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (w - 1));
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/arm_kinematics_gravity_torque.sv =====
// Two-link arm forward kinematics and gravity torque, top level.
// Uses akg_pkg, akg_cordic and assert_macros.svh.
//
// Input channel in_*: four joint angles (0.01 deg) and comp_on, one item per
// accepted valid/stall handshake. Output channel out_*: position, pitch and
// torques, one item per input item, in order.
// Stages: wrap stage, one stage per CORDIC step, three multiply/round stages,
// output register. One item enters every cycle while in_stall is low; the rate
// is set by the fully pipelined CORDIC, one step per stage.
// All stages move together: while the output register holds an item that the
// receiver stalls, in_stall is high and nothing moves, so no item is lost or
// repeated. An empty output register lets the pipe advance.
// Reset clears all valid bits and loads register defaults (offsets 0, frame
// scale 1.0, torque scales 1.0). No clearing pass is needed.
// Config: APB-style port, register i at byte address 4*i, pready always high.
// Write registers only while the pipe is empty.
`default_nettype none
`include "assert_macros.svh"
module arm_kinematics_gravity_torque import akg_pkg::*; #(
  parameter int CORDIC_STEPS = AKG_CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [16:0] in_angle_base,
  input  wire logic signed [16:0] in_angle_shoulder,
  input  wire logic signed [16:0] in_angle_elbow,
  input  wire logic signed [16:0] in_angle_wrist,
  input  wire logic               in_comp_on,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_pos_x,
  output logic signed [23:0]      out_pos_y,
  output logic signed [23:0]      out_pos_z,
  output logic signed [17:0]      out_pitch,
  output logic signed [19:0]      out_torque_shoulder,
  output logic signed [19:0]      out_torque_elbow,
  output logic                    out_torque_valid,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  localparam logic [2:0] REG_OFS_X   = 3'd0;
  localparam logic [2:0] REG_OFS_Y   = 3'd1;
  localparam logic [2:0] REG_OFS_Z   = 3'd2;
  localparam logic [2:0] REG_FSCALE  = 3'd3;
  localparam logic [2:0] REG_POFS    = 3'd4;
  localparam logic [2:0] REG_SCALE2  = 3'd5;
  localparam logic [2:0] REG_SCALE3  = 3'd6;

  // ---------------- configuration registers ----------------
  logic signed [17:0] ofs_x_r, ofs_y_r, ofs_z_r;
  logic        [15:0] fscale_r;
  logic signed [16:0] pofs_r;
  logic        [15:0] scale2_r, scale3_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r  <= '0;
      ofs_y_r  <= '0;
      ofs_z_r  <= '0;
      fscale_r <= 16'd256;
      pofs_r   <= '0;
      scale2_r <= 16'd4096;
      scale3_r <= 16'd4096;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OFS_X:  ofs_x_r  <= cfg_pwdata[17:0];
        REG_OFS_Y:  ofs_y_r  <= cfg_pwdata[17:0];
        REG_OFS_Z:  ofs_z_r  <= cfg_pwdata[17:0];
        REG_FSCALE: fscale_r <= cfg_pwdata[15:0];
        REG_POFS:   pofs_r   <= cfg_pwdata[16:0];
        REG_SCALE2: scale2_r <= cfg_pwdata[15:0];
        REG_SCALE3: scale3_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_OFS_X:  cfg_prdata = {14'd0, ofs_x_r};
      REG_OFS_Y:  cfg_prdata = {14'd0, ofs_y_r};
      REG_OFS_Z:  cfg_prdata = {14'd0, ofs_z_r};
      REG_FSCALE: cfg_prdata = {16'd0, fscale_r};
      REG_POFS:   cfg_prdata = {15'd0, pofs_r};
      REG_SCALE2: cfg_prdata = {16'd0, scale2_r};
      REG_SCALE3: cfg_prdata = {16'd0, scale3_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic accept;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && !in_stall;

  // ---------------- stage 0: wrap angles, pitch ----------------
  akg_ang_t           ab_nxt, as_nxt, ae_nxt;
  akg_ang_t           ab_r, as_r, ae_r;
  logic signed [18:0] pitch_sum;
  logic signed [17:0] pitch0_r;
  logic               comp0_r;
  logic               v0_r;

  assign ab_nxt    = akg_wrap(in_angle_base);
  assign as_nxt    = akg_wrap(in_angle_shoulder);
  assign ae_nxt    = akg_wrap(in_angle_elbow);
  assign pitch_sum = 19'(in_angle_wrist) + 19'(in_angle_elbow) - 19'(pofs_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ab_r     <= ab_nxt;
      as_r     <= as_nxt;
      ae_r     <= ae_nxt;
      pitch0_r <= 18'(akg_sat(64'(pitch_sum), 18));
      comp0_r  <= in_comp_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end

  // ---------------- CORDIC stages ----------------
  logic signed [AKG_SCW-1:0] sb, cb, ss, cs, se, ce;

  akg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk(clk), .en(en), .z_in(ab_r.z), .flip_in(ab_r.flip), .sin_out(sb), .cos_out(cb)
  );
  akg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_s (
    .clk(clk), .en(en), .z_in(as_r.z), .flip_in(as_r.flip), .sin_out(ss), .cos_out(cs)
  );
  akg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_e (
    .clk(clk), .en(en), .z_in(ae_r.z), .flip_in(ae_r.flip), .sin_out(se), .cos_out(ce)
  );

  // side data and valid bits travel alongside the CORDIC
  logic signed [17:0] pitch_d_r [CORDIC_STEPS];
  logic               comp_d_r  [CORDIC_STEPS];
  logic               vc_r      [CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_d_r[0] <= pitch0_r;
      comp_d_r[0]  <= comp0_r;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        pitch_d_r[k] <= pitch_d_r[k-1];
        comp_d_r[k]  <= comp_d_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_STEPS; k++) vc_r[k] <= 1'b0;
    end else if (en) begin
      vc_r[0] <= v0_r;
      for (int k = 1; k < CORDIC_STEPS; k++) vc_r[k] <= vc_r[k-1];
    end
  end

  // ---------------- P1: link lengths and weight constants ----------------
  logic signed [35:0]        px1_r, h1_r;
  logic signed [43:0]        t2s1_r;
  logic signed [42:0]        t3s1_r;
  logic signed [AKG_SCW-1:0] sb1_r, cb1_r;
  logic signed [17:0]        pitch1_r;
  logic                      comp1_r, v1_r;
  logic signed [35:0]        px_nxt, h_nxt;
  logic signed [43:0]        t2s_nxt;
  logic signed [42:0]        t3s_nxt;

  assign px_nxt  = AKG_LEN1 * ss + AKG_LEN2 * se;
  assign h_nxt   = AKG_LEN1 * cs + AKG_LEN2 * ce;
  assign t2s_nxt = AKG_TQ_A * cs + AKG_TQ_B * ce;
  assign t3s_nxt = AKG_TQ_C * ce;

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r    <= px_nxt;
      h1_r     <= h_nxt;
      t2s1_r   <= t2s_nxt;
      t3s1_r   <= t3s_nxt;
      sb1_r    <= sb;
      cb1_r    <= cb;
      pitch1_r <= pitch_d_r[CORDIC_STEPS-1];
      comp1_r  <= comp_d_r[CORDIC_STEPS-1];
    end
  end

  // ---------------- P2: base rotation, torque scaling ----------------
  logic signed [53:0] hsb, hcb;
  logic signed [60:0] t2p_nxt;
  logic signed [59:0] t3p_nxt;
  logic signed [37:0] px2_r, py2_r, pz2_r;
  logic signed [60:0] t2p2_r;
  logic signed [59:0] t3p2_r;
  logic signed [17:0] pitch2_r;
  logic               comp2_r, v2_r;
  logic signed [53:0] hsb_rnd, hcb_rnd;

  assign hsb     = h1_r * sb1_r;
  assign hcb     = h1_r * cb1_r;
  assign hsb_rnd = (hsb + 54'sd32768) >>> 16;
  assign hcb_rnd = (hcb + 54'sd32768) >>> 16;
  assign t2p_nxt = $signed({1'b0, scale2_r}) * t2s1_r;
  assign t3p_nxt = $signed({1'b0, scale3_r}) * t3s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r    <= 38'(px1_r);
      py2_r    <= -hsb_rnd[37:0];
      pz2_r    <= hcb_rnd[37:0];
      t2p2_r   <= t2p_nxt;
      t3p2_r   <= t3p_nxt;
      pitch2_r <= pitch1_r;
      comp2_r  <= comp1_r;
    end
  end

  // ---------------- P3: offset and frame scale, torque round ----------------
  logic signed [39:0] sx, sy, sz;
  logic signed [16:0] fs_s;
  logic signed [56:0] qx3_r, qy3_r, qz3_r;
  logic signed [60:0] t2_rnd;
  logic signed [59:0] t3_rnd;
  logic signed [19:0] t23_r, t33_r;
  logic signed [17:0] pitch3_r;
  logic               comp3_r, v3_r;

  assign fs_s   = $signed({1'b0, fscale_r});
  assign sx     = (40'(ofs_x_r) <<< 16) + 40'(px2_r);
  assign sy     = (40'(ofs_y_r) <<< 16) + 40'(py2_r);
  assign sz     = (40'(ofs_z_r) <<< 16) + 40'(pz2_r);
  assign t2_rnd = (t2p2_r + (61'sd1 <<< 35)) >>> 36;
  assign t3_rnd = (t3p2_r + (60'sd1 <<< 35)) >>> 36;

  always_ff @(posedge clk) begin
    if (en) begin
      qx3_r    <= sx * fs_s;
      qy3_r    <= sy * fs_s;
      qz3_r    <= sz * fs_s;
      t23_r    <= comp2_r ? 20'(akg_sat(64'(t2_rnd), 20)) : '0;
      t33_r    <= comp2_r ? 20'(akg_sat(64'(t3_rnd), 20)) : '0;
      pitch3_r <= pitch2_r;
      comp3_r  <= comp2_r;
    end
  end

  // ---------------- P4: round and saturate into the output register ----------------
  logic signed [56:0] qx_rnd, qy_rnd, qz_rnd;
  assign qx_rnd = (qx3_r + (57'sd1 <<< 23)) >>> 24;
  assign qy_rnd = (qy3_r + (57'sd1 <<< 23)) >>> 24;
  assign qz_rnd = (qz3_r + (57'sd1 <<< 23)) >>> 24;

  logic signed [23:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [17:0] out_pitch_r;
  logic signed [19:0] out_tq_sh_r, out_tq_el_r;
  logic               out_tq_v_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x_r <= 24'(akg_sat(64'(qx_rnd), 24));
      out_pos_y_r <= 24'(akg_sat(64'(qy_rnd), 24));
      out_pos_z_r <= 24'(akg_sat(64'(qz_rnd), 24));
      out_pitch_r <= pitch3_r;
      out_tq_sh_r <= t23_r;
      out_tq_el_r <= t33_r;
      out_tq_v_r  <= comp3_r;
    end
  end

  // valid bits after the CORDIC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= vc_r[CORDIC_STEPS-1];
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pos_x           = out_pos_x_r;
  assign out_pos_y           = out_pos_y_r;
  assign out_pos_z           = out_pos_z_r;
  assign out_pitch           = out_pitch_r;
  assign out_torque_shoulder = out_tq_sh_r;
  assign out_torque_elbow    = out_tq_el_r;
  assign out_torque_valid    = out_tq_v_r;

  // ---------------- assertions ----------------
  `AKG_ASSERT(a_empty_no_stall, !out_valid_r |-> !in_stall, "stall with empty output register")
  `AKG_ASSERT(a_accept_enters, accept |=> v0_r, "accepted item did not enter stage 0")
  `AKG_ASSERT(a_tq_off_zero, (out_valid_r && !out_tq_v_r) |-> (out_tq_sh_r == '0 && out_tq_el_r == '0), "torques nonzero with compensation off")
  `AKG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && !v0_r, "valid bits not cleared by reset")
endmodule
`default_nettype wire

// ===== rtl/core/akg_cordic.sv =====
// Pipelined rotation-mode CORDIC, one step per register stage, sine and cosine in Q16.
// Depends on akg_pkg.
`default_nettype none
module akg_cordic import akg_pkg::*; #(
  parameter int CORDIC_STEPS = AKG_CORDIC_STEPS
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [AKG_ZW-1:0]  z_in,
  input  wire logic                      flip_in,
  output logic signed [AKG_SCW-1:0]      sin_out,
  output logic signed [AKG_SCW-1:0]      cos_out
);
  logic signed [AKG_XW-1:0] x_r [CORDIC_STEPS];
  logic signed [AKG_XW-1:0] y_r [CORDIC_STEPS];
  logic signed [AKG_ZW-1:0] z_r [CORDIC_STEPS];
  logic                     flip_r [CORDIC_STEPS];
  logic signed [AKG_XW-1:0] x_rnd;
  logic signed [AKG_XW-1:0] y_rnd;

  // one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [AKG_XW-1:0] xi, yi, x_nxt, y_nxt;
    logic signed [AKG_ZW-1:0] zi, z_nxt;
    logic                     fi;
    if (k == 0) begin : g_first
      assign xi = AKG_GAIN_Q30;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign fi = flip_r[k-1];
    end
    always_comb begin
      if (zi >= 0) begin
        x_nxt = xi - (yi >>> k);
        y_nxt = yi + (xi >>> k);
        z_nxt = zi - AKG_ATAN[k];
      end else begin
        x_nxt = xi + (yi >>> k);
        y_nxt = yi - (xi >>> k);
        z_nxt = zi + AKG_ATAN[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        flip_r[k] <= fi;
      end
    end
  end

  // round Q30 to Q16, half up; cosine takes the quadrant flip
  assign x_rnd   = (x_r[CORDIC_STEPS-1] + AKG_XW'(1 <<< 13)) >>> 14;
  assign y_rnd   = (y_r[CORDIC_STEPS-1] + AKG_XW'(1 <<< 13)) >>> 14;
  assign sin_out = y_rnd[AKG_SCW-1:0];
  assign cos_out = flip_r[CORDIC_STEPS-1] ? -x_rnd[AKG_SCW-1:0] : x_rnd[AKG_SCW-1:0];
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for arm_kinematics_gravity_torque: drives joint-angle items, predicts
// position, pitch and gravity torques, and checks every result item in order.
// Depends on akg_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import akg_pkg::*;

  localparam int LATENCY = AKG_CORDIC_STEPS + 5;

  // register indexes
  typedef enum int {
    REG_OFS_X = 0, REG_OFS_Y = 1, REG_OFS_Z = 2, REG_FRAME_SCALE = 3,
    REG_PITCH_OFS = 4, REG_SCALE_J2 = 5, REG_SCALE_J3 = 6
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [17:0] pitch;
    logic signed [19:0] torque_shoulder;
    logic signed [19:0] torque_elbow;
    logic               torque_valid;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [16:0] in_angle_base = '0, in_angle_shoulder = '0;
  logic signed [16:0] in_angle_elbow = '0, in_angle_wrist = '0;
  logic in_comp_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  pose_t got;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  arm_kinematics_gravity_torque u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_base(in_angle_base), .in_angle_shoulder(in_angle_shoulder),
    .in_angle_elbow(in_angle_elbow), .in_angle_wrist(in_angle_wrist),
    .in_comp_on(in_comp_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(got.pos_x), .out_pos_y(got.pos_y), .out_pos_z(got.pos_z),
    .out_pitch(got.pitch), .out_torque_shoulder(got.torque_shoulder),
    .out_torque_elbow(got.torque_elbow), .out_torque_valid(got.torque_valid),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow registers
  longint ofs_x, ofs_y, ofs_z, frame_scale, pitch_ofs, scale_j2, scale_j3;
  pose_t expected_poses[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -(longint'(1) <<< (w - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // CORDIC sine and cosine in Q16 of an angle in 0.01 degree
  task automatic sin_cos_q16(input longint ang, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = ang % 36000;
    flip = 1'b0;
    if (r < 0) r += 36000;
    if (r > 18000) r -= 36000;
    if (r > 9000) begin
      r = 18000 - r;
      flip = 1'b1;
    end else if (r < -9000) begin
      r = -18000 - r;
      flip = 1'b1;
    end
    x = AKG_GAIN_Q30;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < AKG_CORDIC_STEPS && i < AKG_TAB_LEN; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AKG_ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AKG_ATAN[i]);
      end
    end
    sn = round_shr(y, 14);
    cs = flip ? -round_shr(x, 14) : round_shr(x, 14);
  endtask

  task automatic predict_pose(input longint b, input longint s, input longint e,
                              input longint w, input bit comp, output pose_t p);
    longint sb, cb, ss, cs, se, ce, px, h, py, pz;
    sin_cos_q16(b, sb, cb);
    sin_cos_q16(s, ss, cs);
    sin_cos_q16(e, se, ce);
    px = 25300 * ss + 30000 * se;
    h = 25300 * cs + 30000 * ce;
    py = -round_shr(h * sb, 16);
    pz = round_shr(h * cb, 16);
    p.pos_x = 24'(clamp(round_shr((ofs_x * 65536 + px) * frame_scale, 24), 24));
    p.pos_y = 24'(clamp(round_shr((ofs_y * 65536 + py) * frame_scale, 24), 24));
    p.pos_z = 24'(clamp(round_shr((ofs_z * 65536 + pz) * frame_scale, 24), 24));
    p.pitch = 18'(clamp(w + e - pitch_ofs, 18));
    if (comp) begin
      p.torque_shoulder = 20'(clamp(round_shr(scale_j2 * (longint'(AKG_TQ_A) * cs +
                          longint'(AKG_TQ_B) * ce), 36), 20));
      p.torque_elbow = 20'(clamp(round_shr(scale_j3 * (longint'(AKG_TQ_C) * ce), 36), 20));
      p.torque_valid = 1'b1;
    end else begin
      p.torque_shoulder = '0;
      p.torque_elbow = '0;
      p.torque_valid = 1'b0;
    end
  endtask

  // APB write, setup then access
  task automatic write_reg(input reg_idx_t idx, input longint val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 5'(4 * idx); cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_OFS_X:       ofs_x = val;
      REG_OFS_Y:       ofs_y = val;
      REG_OFS_Z:       ofs_z = val;
      REG_FRAME_SCALE: frame_scale = val;
      REG_PITCH_OFS:   pitch_ofs = val;
      REG_SCALE_J2:    scale_j2 = val;
      default:         scale_j3 = val;
    endcase
  endtask

  // send one item; called just after a falling edge, leaves valid high
  // so that the next item can follow with no gap
  task automatic send_angles(input longint b, input longint s, input longint e,
                             input longint w, input bit comp);
    pose_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle_base <= 17'(b); in_angle_shoulder <= 17'(s);
    in_angle_elbow <= 17'(e); in_angle_wrist <= 17'(w); in_comp_on <= comp;
    predict_pose(b, s, e, w, comp, p);
    do @(posedge clk); while (in_stall);
    expected_poses.push_back(p);
    @(negedge clk);
  endtask

  task automatic send_random_angles();
    longint a[4];
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(9))
        0: a[k] = $urandom_range(1) ? 36000 : -36000;
        1: a[k] = longint'(9000 * (int'($urandom_range(8)) - 4) +
                  int'($urandom_range(2)) - 1);
        2: a[k] = longint'($signed(17'($urandom)));
        default: a[k] = longint'($urandom_range(72000)) - 36000;
      endcase
    end
    send_angles(a[0], a[1], a[2], a[3], 1'($urandom_range(1)));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_poses.size() > 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pose_t exp_p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
      end else begin
        exp_p = expected_poses.pop_front();
        if (got.pos_x !== exp_p.pos_x) begin
          $display("%0t: pos_x exp %0d got %0d", $time, exp_p.pos_x, got.pos_x); errors++;
        end
        if (got.pos_y !== exp_p.pos_y) begin
          $display("%0t: pos_y exp %0d got %0d", $time, exp_p.pos_y, got.pos_y); errors++;
        end
        if (got.pos_z !== exp_p.pos_z) begin
          $display("%0t: pos_z exp %0d got %0d", $time, exp_p.pos_z, got.pos_z); errors++;
        end
        if (got.pitch !== exp_p.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, exp_p.pitch, got.pitch); errors++;
        end
        if (got.torque_shoulder !== exp_p.torque_shoulder) begin
          $display("%0t: torque_shoulder exp %0d got %0d", $time,
                   exp_p.torque_shoulder, got.torque_shoulder); errors++;
        end
        if (got.torque_elbow !== exp_p.torque_elbow) begin
          $display("%0t: torque_elbow exp %0d got %0d", $time,
                   exp_p.torque_elbow, got.torque_elbow); errors++;
        end
        if (got.torque_valid !== exp_p.torque_valid) begin
          $display("%0t: torque_valid exp %0d got %0d", $time,
                   exp_p.torque_valid, got.torque_valid); errors++;
        end
      end
    end
  end

  // receiver stall, random or held off
  always @(negedge clk) begin
    out_stall <= hold_recv || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // directed: extremes, wrap points, quadrant folds, comp on and off
  task automatic test_directed();
    longint pts[10] = '{0, 36000, -36000, 9000, -9000, 18000, -18000, 27000, 1, -1};
    for (int i = 0; i < 10; i++)
      send_angles(pts[i], pts[(i + 3) % 10], pts[(i + 7) % 10], pts[i], 1'(i % 2));
    send_angles(-65536, 65535, -65536, 65535, 1'b1);
    send_angles(65535, -65536, 65535, -65536, 1'b0);
    send_angles(9001, 8999, -9001, -8999, 1'b1);
    drain();
  endtask

  // saturation and scale extremes across register settings
  task automatic test_register_extremes();
    write_reg(REG_OFS_X, 100000); write_reg(REG_OFS_Y, -100000);
    write_reg(REG_OFS_Z, 100000); write_reg(REG_FRAME_SCALE, 65535);
    write_reg(REG_PITCH_OFS, -36000); write_reg(REG_SCALE_J2, 65535);
    write_reg(REG_SCALE_J3, 65535);
    repeat (8) send_random_angles();
    send_angles(0, 0, 0, 36000, 1'b1);
    drain();
    write_reg(REG_OFS_X, -100000); write_reg(REG_OFS_Y, 100000);
    write_reg(REG_OFS_Z, -100000); write_reg(REG_FRAME_SCALE, 0);
    write_reg(REG_PITCH_OFS, 36000); write_reg(REG_SCALE_J2, 0);
    write_reg(REG_SCALE_J3, 0);
    repeat (6) send_random_angles();
    send_angles(0, 0, 0, -36000, 1'b1);
    drain();
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_random_angles();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic random_config();
    write_reg(REG_OFS_X, longint'($urandom_range(200000)) - 100000);
    write_reg(REG_OFS_Y, longint'($urandom_range(200000)) - 100000);
    write_reg(REG_OFS_Z, longint'($urandom_range(200000)) - 100000);
    write_reg(REG_FRAME_SCALE, longint'($urandom_range(1023)));
    write_reg(REG_PITCH_OFS, longint'($urandom_range(72000)) - 36000);
    write_reg(REG_SCALE_J2, longint'($urandom_range(65535)));
    write_reg(REG_SCALE_J3, longint'($urandom_range(65535)));
  endtask

  task automatic test_random_traffic();
    random_phase(250, 0, 0);
    random_config();
    random_phase(250, 79, 0);
    random_config();
    random_phase(250, 0, 79);
    write_reg(REG_FRAME_SCALE, 256);
    random_phase(250, 24, 24);
    random_config();
    random_phase(380, 0, 0);
    random_config();
    random_phase(380, 24, 24);
  endtask

  // receiver held off long enough to back up the whole pipe
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (LATENCY * 4) @(negedge clk);
        hold_recv = 1'b0;
      end
      repeat (3 * LATENCY) send_random_angles();
    join
    drain();
  endtask

  initial begin
    ofs_x = 0; ofs_y = 0; ofs_z = 0; frame_scale = 256;
    pitch_ofs = 0; scale_j2 = 4096; scale_j3 = 4096;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    write_reg(REG_OFS_X, 0); write_reg(REG_OFS_Y, 0); write_reg(REG_OFS_Z, 0);
    write_reg(REG_FRAME_SCALE, 256); write_reg(REG_PITCH_OFS, 0);
    write_reg(REG_SCALE_J2, 4096); write_reg(REG_SCALE_J3, 4096);
    test_backpressure();
    test_random_traffic();
    if (errors == 0 && expected_poses.size() == 0) $display("All tests passed");
    else begin
      $display("%0t: %0d results outstanding", $time, expected_poses.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
